>>> rtl/core/i2cbb_pkg.sv
`default_nettype none

package i2cbb_pkg;

    localparam int HpW          = 16;
    localparam int StepW        = 5;
    localparam int ByteW        = 8;
    localparam int ModeW        = 3;
    localparam int InDataW      = 16;
    localparam int OutDataW     = 16;
    localparam int QueueDepth   = 2;
    localparam logic [HpW-1:0] HalfPeriodReset = 16'd10;
    localparam logic [ByteW-1:0] ByteMsb       = 8'h80;

    typedef enum logic [ModeW-1:0] {
        CMD_IDLE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_SEND  = 3'd3,
        CMD_RECV  = 3'd4,
        CMD_SACK  = 3'd5,
        CMD_RACK  = 3'd6
    } cmd_t;

    typedef struct packed {
        logic             is_cmd;
        cmd_t             cmd;
        logic [ByteW-1:0] tx_byte;
        logic             ack_bit;
        logic             sda_level;
    } item_t;

    typedef struct packed {
        logic             rejected;
        logic             rx_ack;
        logic [ByteW-1:0] rx_byte;
        logic             done_res;
        logic             busy_res;
        logic             sda_out;
        logic             scl_out;
    } result_t;

    function automatic logic [StepW-1:0] step_count(input cmd_t cmd);
        logic [StepW-1:0] n;
        case (cmd)
            CMD_START: n = 5'd4;
            CMD_STOP:  n = 5'd3;
            CMD_SEND:  n = 5'd24;
            CMD_RECV:  n = 5'd17;
            CMD_SACK:  n = 5'd3;
            CMD_RACK:  n = 5'd4;
            default:   n = 5'd1;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/i2cbb_front.sv
`default_nettype none

module i2cbb_front (
    input  wire logic [i2cbb_pkg::ModeW-1:0]   mode,
    input  wire logic [i2cbb_pkg::InDataW-1:0] data,
    output i2cbb_pkg::item_t                   item
);
    import i2cbb_pkg::*;

    logic is_cmd;

    always_comb
    begin
        is_cmd = mode inside {[CMD_START:CMD_RACK]};
        item.is_cmd    = is_cmd;
        item.cmd       = is_cmd ? cmd_t'(mode) : CMD_IDLE;
        item.tx_byte   = data[ByteW-1:0];
        item.ack_bit   = data[ByteW];
        item.sda_level = data[ByteW+1];
    end

endmodule

`default_nettype wire

>>> rtl/core/i2cbb_queue.sv
`default_nettype none

module i2cbb_queue #(
    parameter int DEPTH = i2cbb_pkg::QueueDepth
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  i2cbb_pkg::item_t       push_item,
    output logic                   full,
    input  wire logic              pop,
    output i2cbb_pkg::item_t       pop_item,
    output logic                   not_empty
);
    import i2cbb_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FullCnt = CW'(DEPTH);

    item_t         mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    assign full      = (cnt_reg == FullCnt);
    assign not_empty = (cnt_reg != '0);
    assign pop_item  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LastIdx) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LastIdx) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full || pop)
        else $error("request pushed into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("pop from empty queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= FullCnt)
        else $error("queue count out of range");

endmodule

`default_nettype wire

>>> rtl/core/i2cbb_back.sv
`default_nettype none

module i2cbb_back (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [i2cbb_pkg::HpW-1:0]   cfg_wdata,
    input  i2cbb_pkg::item_t                 item,
    input  wire logic                        item_valid,
    output logic                             item_pop,
    output logic                             res_valid,
    output i2cbb_pkg::result_t               res,
    input  wire logic                        res_ready
);
    import i2cbb_pkg::*;

    logic [HpW-1:0]   hp_reg;
    cmd_t             cmd_reg, cmd_next, cmd_a;
    logic [StepW-1:0] step_reg, step_next, step_a;
    logic [HpW-1:0]   timer_reg, timer_next, timer_a, timer_b;
    logic [ByteW-1:0] shift_reg, shift_next, shift_a;
    logic [1:0]       phase_reg, phase_next, phase_a;
    logic             ack_hold_reg, ack_hold_next;
    logic             scl_reg, scl_next;
    logic             sda_reg, sda_next;
    logic             rack_reg, rack_next;
    logic [ByteW-1:0] last_rx_reg, last_rx_next;
    logic             res_valid_reg;
    result_t          res_reg;
    logic             rej, done, change, hold_end, finish;
    logic [HpW-1:0]   h;

    assign item_pop  = item_valid && (!res_valid_reg || res_ready);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign h         = (hp_reg == '0) ? HpW'(1) : hp_reg;

    // command, step and hold timer
    always_comb
    begin
        cmd_a         = cmd_reg;
        step_a        = step_reg;
        timer_a       = timer_reg;
        shift_a       = shift_reg;
        phase_a       = phase_reg;
        ack_hold_next = ack_hold_reg;
        rej           = 1'b0;
        if (cmd_reg == CMD_IDLE)
        begin
            if (item.is_cmd)
            begin
                cmd_a         = item.cmd;
                step_a        = '0;
                timer_a       = '0;
                phase_a       = '0;
                shift_a       = (item.cmd == CMD_SEND) ? item.tx_byte : '0;
                ack_hold_next = item.ack_bit;
            end
        end
        else if (item.is_cmd)
        begin
            rej = 1'b1;
        end
        change   = (cmd_a != CMD_IDLE) && (timer_a == '0);
        timer_b  = change ? h : timer_a;
        hold_end = (cmd_a != CMD_IDLE) && (timer_b == HpW'(1));
        finish   = hold_end && !((step_a + 1'b1) < step_count(cmd_a));
        done     = finish;
        cmd_next   = cmd_a;
        step_next  = step_a;
        timer_next = (cmd_a != CMD_IDLE) ? timer_b - 1'b1 : timer_a;
        if (hold_end)
        begin
            if (finish)
            begin
                cmd_next  = CMD_IDLE;
                step_next = '0;
            end
            else
            begin
                step_next = step_a + 1'b1;
            end
        end
    end

    // line levels, shift register and sampled data
    always_comb
    begin
        scl_next     = scl_reg;
        sda_next     = sda_reg;
        shift_next   = shift_a;
        phase_next   = phase_a;
        rack_next    = rack_reg;
        last_rx_next = last_rx_reg;
        if (change)
        begin
            case (cmd_a)
                CMD_START:
                begin
                    if (step_a == 5'd0)      sda_next = 1'b1;
                    else if (step_a == 5'd1) scl_next = 1'b1;
                    else if (step_a == 5'd2) sda_next = 1'b0;
                    else                     scl_next = 1'b0;
                end
                CMD_STOP:
                begin
                    if (step_a == 5'd0)      sda_next = 1'b0;
                    else if (step_a == 5'd1) scl_next = 1'b1;
                    else                     sda_next = 1'b1;
                end
                CMD_SEND:
                begin
                    if (phase_a == 2'd0)      sda_next = shift_a[ByteW-1];
                    else if (phase_a == 2'd1) scl_next = 1'b1;
                    else                      scl_next = 1'b0;
                end
                CMD_RECV:
                begin
                    if (step_a == 5'd0) sda_next = 1'b1;
                    else                scl_next = step_a[0];
                end
                CMD_SACK:
                begin
                    if (step_a == 5'd0) sda_next = ack_hold_next;
                    else                scl_next = (step_a == 5'd1);
                end
                CMD_RACK:
                begin
                    if (step_a == 5'd0) sda_next = 1'b1;
                    else                scl_next = (step_a == 5'd1);
                end
                default:
                begin
                end
            endcase
        end
        if (hold_end)
        begin
            if (cmd_a == CMD_SEND)
            begin
                if (phase_a == 2'd2)
                begin
                    phase_next = '0;
                    shift_next = shift_a << 1;
                end
                else
                begin
                    phase_next = phase_a + 1'b1;
                end
            end
            else if (cmd_a == CMD_RECV && step_a[0])
            begin
                shift_next = {shift_a[ByteW-2:0], item.sda_level};
            end
            else if (cmd_a == CMD_RACK && step_a == 5'd1)
            begin
                rack_next = item.sda_level;
            end
            if (finish && cmd_a == CMD_RECV)
            begin
                last_rx_next = shift_a;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hp_reg        <= HalfPeriodReset;
            cmd_reg       <= CMD_IDLE;
            step_reg      <= '0;
            timer_reg     <= '0;
            shift_reg     <= '0;
            phase_reg     <= '0;
            ack_hold_reg  <= 1'b0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            rack_reg      <= 1'b0;
            last_rx_reg   <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                hp_reg <= cfg_wdata;
            end
            if (item_pop)
            begin
                cmd_reg      <= cmd_next;
                step_reg     <= step_next;
                timer_reg    <= timer_next;
                shift_reg    <= shift_next;
                phase_reg    <= phase_next;
                ack_hold_reg <= ack_hold_next;
                scl_reg      <= scl_next;
                sda_reg      <= sda_next;
                rack_reg     <= rack_next;
                last_rx_reg  <= last_rx_next;
            end
            if (item_pop)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_pop)
        begin
            res_reg.scl_out  <= scl_next;
            res_reg.sda_out  <= sda_next;
            res_reg.busy_res <= (cmd_next != CMD_IDLE);
            res_reg.done_res <= done;
            res_reg.rx_byte  <= last_rx_next;
            res_reg.rx_ack   <= rack_next;
            res_reg.rejected <= rej;
        end
    end

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        item_pop |=> !(res_reg.done_res && res_reg.busy_res))
        else $error("done reported while still busy");

    a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_pop && rej |-> cmd_reg != CMD_IDLE)
        else $error("request rejected while idle");

    a_idle_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_reg == CMD_IDLE |-> step_reg == '0)
        else $error("step index left over in idle");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_reg != CMD_IDLE |-> step_reg < step_count(cmd_reg))
        else $error("step index past end of sequence");

endmodule

`default_nettype wire

>>> rtl/core/i2c_bitbang_master.sv
// I2C master line sequencer: every request on the slave stream is one timebase tick and
// yields exactly one result on the master stream. A command (start, stop, send byte,
// receive byte, send ack, receive ack) is taken only when idle, else it is flagged as
// rejected; after each SCL/SDA change the lines hold for half_period ticks (zero counts
// as one). One tick is accepted per clock cycle while m_tready does not hold back results,
// as the sequencer updates its step and hold counter with each tick it takes; a result
// passes through the request queue and then the output register.
`default_nettype none

module i2c_bitbang_master #(
    parameter int QUEUE_DEPTH = i2cbb_pkg::QueueDepth
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [i2cbb_pkg::HpW-1:0]        cfg_wdata,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // tx_byte[7:0], ack_bit[8], sda_level[9], zero[15:10]
    input  wire logic [i2cbb_pkg::InDataW-1:0]    s_tdata,
    // mode[2:0]
    input  wire logic [i2cbb_pkg::ModeW-1:0]      s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // scl_out[0], sda_out[1], busy_res[2], done_res[3], rx_byte[11:4], rx_ack[12],
    // rejected[13], zero[15:14]
    output logic [i2cbb_pkg::OutDataW-1:0]        m_tdata
);
    import i2cbb_pkg::*;

    item_t   in_item, q_item;
    result_t res;
    logic    q_full, q_valid, q_pop, push;

    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full;
    assign m_tdata  = {{(OutDataW - $bits(result_t)){1'b0}}, res};

    i2cbb_front u_front (
        .mode (s_tuser),
        .data (s_tdata),
        .item (in_item)
    );

    i2cbb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (in_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (q_item),
        .not_empty (q_valid)
    );

    i2cbb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .item       (q_item),
        .item_valid (q_valid),
        .item_pop   (q_pop),
        .res_valid  (m_tvalid),
        .res        (res),
        .res_ready  (m_tready)
    );

endmodule

`default_nettype wire

>>> tb/sv/i2cbb_line_checker.sv
`default_nettype none

module i2cbb_line_checker
    import i2cbb_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [HpW-1:0]      cfg_wdata,
    input  wire logic                s_tvalid,
    input  wire logic                s_tready,
    input  wire logic [InDataW-1:0]  s_tdata,
    input  wire logic [ModeW-1:0]    s_tuser,
    input  wire logic                m_tvalid,
    input  wire logic                m_tready,
    input  wire logic [OutDataW-1:0] m_tdata,
    output int                       fail_count,
    output int                       pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ResW = $bits(result_t);

    logic [HpW-1:0]   hold_ticks;
    cmd_t             run_cmd;
    logic [StepW-1:0] step;
    logic [HpW-1:0]   hold_left;
    logic [ByteW-1:0] shreg;
    logic             ack_drive;
    logic             scl_q;
    logic             sda_q;
    logic             ack_seen;
    logic [ByteW-1:0] rx_last;
    result_t          line_q[$];

    function automatic int steps_in(input cmd_t c);
        case (c)
            CMD_START: return 4;
            CMD_STOP:  return 3;
            CMD_SEND:  return 24;
            CMD_RECV:  return 17;
            CMD_SACK:  return 3;
            CMD_RACK:  return 4;
            default:   return 1;
        endcase
    endfunction

    task automatic change_lines(input cmd_t c, input logic [StepW-1:0] s);
        int b;
        b = s / 3;
        case (c)
            CMD_START:
                case (s)
                    5'd0:    sda_q = 1'b1;
                    5'd1:    scl_q = 1'b1;
                    5'd2:    sda_q = 1'b0;
                    default: scl_q = 1'b0;
                endcase
            CMD_STOP:
                case (s)
                    5'd0:    sda_q = 1'b0;
                    5'd1:    scl_q = 1'b1;
                    default: sda_q = 1'b1;
                endcase
            CMD_SEND:
                case (s % 3)
                    0:       sda_q = shreg[7 - b];
                    1:       scl_q = 1'b1;
                    default: scl_q = 1'b0;
                endcase
            CMD_RECV:
                if (s == 5'd0) sda_q = 1'b1;
                else scl_q = s[0];
            CMD_SACK:
                if (s == 5'd0) sda_q = ack_drive;
                else scl_q = (s == 5'd1);
            CMD_RACK:
                if (s == 5'd0) sda_q = 1'b1;
                else scl_q = (s == 5'd1);
            default: ;
        endcase
    endtask

    // sample at the last tick of an SCL-high hold
    task automatic sample_sda(input cmd_t c, input logic [StepW-1:0] s, input logic sda);
        if (c == CMD_RECV && s[0]) begin
            if (sda) shreg[7 - ((s - 1) >> 1)] = 1'b1;
        end else if (c == CMD_RACK && s == 5'd1) begin
            ack_seen = sda;
        end
    endtask

    task automatic take_tick(input logic [ModeW-1:0] mode, input logic [ByteW-1:0] tx,
                             input logic ack, input logic sda, output result_t r);
        logic [HpW-1:0] h;
        logic           cmd_req;
        r = '0;
        h = (hold_ticks == '0) ? HpW'(1) : hold_ticks;
        cmd_req = (mode >= CMD_START) && (mode <= CMD_RACK);
        if (run_cmd == CMD_IDLE) begin
            if (cmd_req) begin
                run_cmd   = cmd_t'(mode);
                step      = '0;
                shreg     = (mode == CMD_SEND) ? tx : '0;
                ack_drive = ack;
                hold_left = '0;
            end
        end else if (cmd_req) begin
            r.rejected = 1'b1;
        end
        if (run_cmd != CMD_IDLE) begin
            if (hold_left == '0) begin
                change_lines(run_cmd, step);
                hold_left = h;
            end
            hold_left = hold_left - 1'b1;
            if (hold_left == '0) begin
                sample_sda(run_cmd, step, sda);
                if (int'(step) + 1 < steps_in(run_cmd)) begin
                    step = step + 1'b1;
                end else begin
                    if (run_cmd == CMD_RECV) rx_last = shreg;
                    run_cmd    = CMD_IDLE;
                    step       = '0;
                    r.done_res = 1'b1;
                end
            end
        end
        r.scl_out  = scl_q;
        r.sda_out  = sda_q;
        r.busy_res = (run_cmd != CMD_IDLE);
        r.rx_byte  = rx_last;
        r.rx_ack   = ack_seen;
    endtask

    function automatic void compare_field(input string name, input int want_v, input int got_v);
        if (want_v != got_v) begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        result_t got;
        result_t want;
        if (!rst_n) begin
            hold_ticks = HalfPeriodReset;
            run_cmd    = CMD_IDLE;
            step       = '0;
            hold_left  = '0;
            shreg      = '0;
            ack_drive  = 1'b0;
            scl_q      = 1'b1;
            sda_q      = 1'b1;
            ack_seen   = 1'b0;
            rx_last    = '0;
            line_q.delete();
            fail_count = 0;
            pending    = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata[ResW-1:0]);
                if (line_q.size() == 0) begin
                    $error("result with no request pending: %h", m_tdata);
                    fail_count++;
                end else begin
                    want = line_q.pop_front();
                    compare_field("scl_out", want.scl_out, got.scl_out);
                    compare_field("sda_out", want.sda_out, got.sda_out);
                    compare_field("busy_res", want.busy_res, got.busy_res);
                    compare_field("done_res", want.done_res, got.done_res);
                    compare_field("rx_byte", want.rx_byte, got.rx_byte);
                    compare_field("rx_ack", want.rx_ack, got.rx_ack);
                    compare_field("rejected", want.rejected, got.rejected);
                    compare_field("pad", 0, m_tdata[OutDataW-1:ResW]);
                end
            end
            if (cfg_we) hold_ticks = cfg_wdata;
            if (s_tvalid && s_tready) begin
                take_tick(s_tuser, s_tdata[7:0], s_tdata[8], s_tdata[9], want);
                line_q.push_back(want);
            end
            pending = line_q.size();
        end
    end

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import i2cbb_pkg::*;

    localparam logic [ModeW-1:0] MODE_RESERVED = 3'd7;
    localparam int SDA_LOW  = 0;
    localparam int SDA_HIGH = 1;
    localparam int SDA_RAND = 2;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [HpW-1:0]      cfg_wdata = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [InDataW-1:0]  s_tdata   = '0;
    logic [ModeW-1:0]    s_tuser   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [OutDataW-1:0] m_tdata;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int cur_hp      = HalfPeriodReset;
    int fail_count;
    int pending;

    i2c_bitbang_master u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    i2cbb_line_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("tb: errors");
        $finish;
    end

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    task automatic send_tick(input logic [ModeW-1:0] mode, input logic [ByteW-1:0] tx,
                             input logic ack, input int sda_sel);
        logic sda;
        sda = (sda_sel == SDA_RAND) ? 1'($urandom_range(0, 1)) : (sda_sel == SDA_HIGH);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {{(InDataW - 10){1'b0}}, sda, ack, tx};
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic run_command(input logic [ModeW-1:0] mode, input logic [ByteW-1:0] tx,
                               input logic ack, input int sda_sel, input int pad);
        send_tick(mode, tx, ack, sda_sel);
        repeat (pad) send_tick(CMD_IDLE, 8'($urandom), 1'($urandom), sda_sel);
    endtask

    // hold the request stream until every result is back, then write
    task automatic write_half_period(input int hp);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= HpW'(hp);
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_hp = hp;
    endtask

    task automatic random_ticks(input int n);
        int               pick;
        logic [ModeW-1:0] mode;
        repeat (n)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 78) mode = CMD_IDLE;
            else if (pick < 97) mode = ModeW'($urandom_range(CMD_START, CMD_RACK));
            else mode = MODE_RESERVED;
            send_tick(mode, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), SDA_RAND);
        end
        // let the longest sequence run out
        repeat (24 * cur_hp) send_tick(CMD_IDLE, 8'($urandom), 1'($urandom), SDA_RAND);
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_command(CMD_START, 8'h00, 1'b0, SDA_RAND, 4 * HalfPeriodReset - 1);

        write_half_period(1);
        run_command(CMD_SEND, 8'hFF, 1'b0, SDA_RAND, 23);
        run_command(CMD_SEND, 8'h00, 1'b0, SDA_RAND, 23);
        run_command(CMD_SEND, 8'h96, 1'b1, SDA_RAND, 23);
        run_command(CMD_RECV, 8'h00, 1'b0, SDA_HIGH, 16);
        run_command(CMD_RECV, 8'h00, 1'b0, SDA_LOW, 16);
        run_command(CMD_RECV, 8'h00, 1'b0, SDA_RAND, 16);
        run_command(CMD_SACK, 8'h00, 1'b0, SDA_RAND, 2);
        run_command(CMD_SACK, 8'h00, 1'b1, SDA_RAND, 2);
        run_command(CMD_RACK, 8'h00, 1'b0, SDA_HIGH, 3);
        run_command(CMD_RACK, 8'h00, 1'b0, SDA_LOW, 3);
        run_command(CMD_STOP, 8'h00, 1'b0, SDA_RAND, 2);
        run_command(MODE_RESERVED, 8'h00, 1'b0, SDA_RAND, 0);

        // commands while busy get dropped
        run_command(CMD_SEND, 8'h5A, 1'b0, SDA_RAND, 0);
        run_command(CMD_START, 8'h00, 1'b0, SDA_RAND, 0);
        run_command(CMD_STOP, 8'h00, 1'b0, SDA_RAND, 0);
        run_command(CMD_RECV, 8'h00, 1'b0, SDA_RAND, 0);
        run_command(CMD_SACK, 8'h00, 1'b1, SDA_RAND, 0);
        run_command(CMD_RACK, 8'h00, 1'b0, SDA_RAND, 0);
        run_command(CMD_SEND, 8'hC3, 1'b0, SDA_RAND, 17);

        write_half_period(0);
        run_command(CMD_START, 8'h00, 1'b0, SDA_RAND, 3);
        run_command(CMD_RACK, 8'h00, 1'b0, SDA_RAND, 3);
        run_command(CMD_STOP, 8'h00, 1'b0, SDA_RAND, 2);

        for (int p = 0; p < 3; p++)
        begin
            tx_idle_pct = (p == 0) ? 6 : (p == 1) ? 84 : 0;
            rx_idle_pct = (p == 0) ? 84 : (p == 1) ? 6 : 0;
            write_half_period((p == 0) ? 2 : (p == 1) ? 1 : 4);
            random_ticks(60);
        end

        write_half_period(65535);
        run_command(CMD_RACK, 8'h00, 1'b0, SDA_RAND, 7);

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending == 0)
        begin
            $display("tb: clean");
        end
        else
        begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
rtl/core/i2cbb_pkg.sv
rtl/core/i2cbb_front.sv
rtl/core/i2cbb_queue.sv
rtl/core/i2cbb_back.sv
rtl/core/i2c_bitbang_master.sv
tb/sv/i2cbb_line_checker.sv
tb/sv/tb.sv
